// ----- rtl/core/plid_pkg.sv -----
// ----------------------------------------------------------------------------
// plid_pkg
// Shared sizes, codes and cell control word for the positional list core.
// ----------------------------------------------------------------------------
package plid_pkg;

	// list capacity and derived widths
	localparam int DEPTH = 64;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 8;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int DATA_W = 32;
	localparam int ECNT_W = 7;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_NOPOS = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	// what every cell does on the broadcast control word
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_op_t;

	// broadcast control word: sel is the insert/delete place, or the tail on rotate
	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] sel;
	} cell_ctl_t;

endpackage

// ----- rtl/core/plid_cell.sv -----
// ----------------------------------------------------------------------------
// plid_cell
// One list slot: holds an entry and moves it to a neighbour on command.
// ----------------------------------------------------------------------------
module plid_cell import plid_pkg::*; (
	input  logic              clk,
	input  logic [IDX_W-1:0]  idx,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] left_val,
	input  logic [DATA_W-1:0] right_val,
	input  logic [DATA_W-1:0] head_val,
	input  logic [DATA_W-1:0] ins_val,
	output logic [DATA_W-1:0] entry
);

	logic [DATA_W-1:0] entry_q;

	// pick the next entry from this slot's neighbours, the head or the insert value
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_INS: begin
				if (idx > ctl.sel) begin
					entry_q <= left_val;
				end else if (idx == ctl.sel) begin
					entry_q <= ins_val;
				end
			end
			CELL_DEL: begin
				if (idx >= ctl.sel) begin
					entry_q <= right_val;
				end
			end
			CELL_ROT: begin
				if (idx == ctl.sel) begin
					entry_q <= head_val;
				end else if (idx < ctl.sel) begin
					entry_q <= right_val;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;

endmodule

// ----- rtl/core/plid_chain.sv -----
// ----------------------------------------------------------------------------
// plid_chain
// Row of list cells wired to their neighbours; the head cell feeds the dump.
// ----------------------------------------------------------------------------
module plid_chain import plid_pkg::*; (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] ins_val,
	output logic [DATA_W-1:0] head_val
);

	logic [DATA_W-1:0] entry_w [DEPTH];

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [DATA_W-1:0] left_w;
			logic [DATA_W-1:0] right_w;

			// tie off the ends of the row
			if (g == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = entry_w[g-1];
			end
			if (g == DEPTH - 1) begin : g_end
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = entry_w[g+1];
			end

			plid_cell u_cell (
				.clk       (clk),
				.idx       (IDX_W'(g)),
				.ctl       (ctl),
				.left_val  (left_w),
				.right_val (right_w),
				.head_val  (entry_w[0]),
				.ins_val   (ins_val),
				.entry     (entry_w[g])
			);
		end
	endgenerate

	assign head_val = entry_w[0];

endmodule

// ----- rtl/core/positional_list_insert_delete_core.sv -----
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core
// Packed list of signed words with insert, delete and dump by position.
// ----------------------------------------------------------------------------
// Insert and delete each shift the whole row of cells at once, and one
// status word follows. Dump emits one word per cycle while the result side
// does not stall, N words for N entries, by rotating the occupied part of
// the row through the head cell; the list is back in place when the last
// word goes out. The core stays in its dump state until then, and a stall
// on the result side holds it there longer.
// One command is worked on at a time, and the next is taken as soon as the
// output register is free or being drained. An insert into a full list is
// refused with a full status and leaves the list unchanged.
module positional_list_insert_delete_core import plid_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               command,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] value_out,
	output logic [ECNT_W-1:0]        entry_count,
	output logic [1:0]               status,
	output logic                     last
);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   dump_idx_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  value_q;
	logic [CNT_W-1:0]   cnt_out_q;
	status_t            status_q;
	logic               last_q;

	logic               take_out;
	logic               in_acc;
	logic               dump_step;
	logic               full;
	logic               pos_ge_cnt;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   cnt_x;
	logic [CNT_W-1:0]   cnt_m1;
	logic [IDX_W-1:0]   tail;
	logic               at_tail;
	logic [DATA_W-1:0]  head_val;
	cell_ctl_t          ctl;
	logic [CNT_W+ECNT_W-1:0] cnt_ext;

	// handshake and compare terms
	assign take_out   = !out_valid_q || !out_stall;
	assign in_stall   = !((state_q == S_IDLE) && take_out);
	assign in_acc     = in_valid && !in_stall;
	assign dump_step  = (state_q == S_DUMP) && take_out;
	assign full       = (count_q == CNT_W'(DEPTH));
	assign pos_x      = CMP_W'(position);
	assign cnt_x      = CMP_W'(count_q);
	assign pos_ge_cnt = (pos_x >= cnt_x);
	assign cnt_m1     = count_q - 1'b1;
	assign tail       = cnt_m1[IDX_W-1:0];
	assign at_tail    = (dump_idx_q == tail);

	// drive the cell row
	always_comb begin
		ctl.op  = CELL_HOLD;
		ctl.sel = '0;
		if (in_acc) begin
			unique case (command)
				CMD_INSERT: begin
					if (!full) begin
						ctl.op  = CELL_INS;
						ctl.sel = pos_ge_cnt ? count_q[IDX_W-1:0] : pos_x[IDX_W-1:0];
					end
				end
				CMD_DELETE: begin
					if (!pos_ge_cnt) begin
						ctl.op  = CELL_DEL;
						ctl.sel = pos_x[IDX_W-1:0];
					end
				end
				default: begin
					ctl.op = CELL_HOLD;
				end
			endcase
		end else if (dump_step) begin
			ctl.op  = CELL_ROT;
			ctl.sel = tail;
		end
	end

	plid_chain u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.ins_val  (value_in),
		.head_val (head_val)
	);

	// sequence commands, track the count and hold the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dump_idx_q  <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			cnt_out_q   <= '0;
			status_q    <= STAT_OK;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				value_q <= '0;
				last_q  <= 1'b1;
				unique case (command)
					CMD_INSERT: begin
						out_valid_q <= 1'b1;
						if (full) begin
							status_q  <= STAT_FULL;
							cnt_out_q <= count_q;
						end else begin
							status_q  <= STAT_OK;
							count_q   <= count_q + 1'b1;
							cnt_out_q <= count_q + 1'b1;
						end
					end
					CMD_DELETE: begin
						out_valid_q <= 1'b1;
						if (pos_ge_cnt) begin
							status_q  <= STAT_NOPOS;
							cnt_out_q <= count_q;
						end else begin
							status_q  <= STAT_OK;
							count_q   <= cnt_m1;
							cnt_out_q <= cnt_m1;
						end
					end
					CMD_DUMP: begin
						cnt_out_q <= count_q;
						if (count_q == '0) begin
							out_valid_q <= 1'b1;
							status_q    <= STAT_EMPTY;
						end else begin
							state_q    <= S_DUMP;
							dump_idx_q <= '0;
						end
					end
					default: begin
						out_valid_q <= 1'b1;
						status_q    <= STAT_OK;
						cnt_out_q   <= count_q;
					end
				endcase
			end else if (dump_step) begin
				out_valid_q <= 1'b1;
				value_q     <= head_val;
				status_q    <= STAT_OK;
				cnt_out_q   <= count_q;
				last_q      <= at_tail;
				dump_idx_q  <= dump_idx_q + 1'b1;
				if (at_tail) begin
					state_q <= S_IDLE;
				end
			end
		end
	end

	// count is reported masked to the field width
	assign cnt_ext     = {{ECNT_W{1'b0}}, cnt_out_q};
	assign out_valid   = out_valid_q;
	assign value_out   = value_q;
	assign entry_count = cnt_ext[ECNT_W-1:0];
	assign status      = status_q;
	assign last        = last_q;

endmodule

// ----- sim/positional_list_insert_delete_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core_tb
// Self-checking bench for the positional list core. A tracker class keeps its
// own copy of the list, predicts every word for each accepted command and
// checks the words that come out. Directed commands cover the empty list, the
// extreme positions and values and the spare command code. Random commands
// then fill the list until inserts are refused and start emptying it, with
// idling on both sides.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_core_tb;
	import plid_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int RANDOM_COMMANDS = 88;
	localparam int RANDOM_CAP = 100;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic [ECNT_W-1:0]        count;
		status_t                  stat;
		logic                     last;
	} list_word_t;

	// tracks the held list and the words still owed by the block
	class list_tracker;
		logic signed [DATA_W-1:0] entries[$];
		list_word_t               owed[$];
		int unsigned failures, commands_seen, words_seen, dumps;
		int unsigned full_rejects, missing_pos, peak;

		function void push_word(logic signed [DATA_W-1:0] value, status_t stat, logic last);
			list_word_t w;
			w.value = value;
			w.count = ECNT_W'(entries.size());
			w.stat  = stat;
			w.last  = last;
			owed.push_back(w);
		endfunction

		// apply an accepted command and queue the words it should produce
		function void note_command(logic [1:0] cmd, logic [POS_W-1:0] pos,
				logic signed [DATA_W-1:0] val);
			int unsigned slot;
			commands_seen++;
			case (cmd)
			CMD_INSERT: begin
				if (entries.size() >= DEPTH) begin
					full_rejects++;
					push_word('0, STAT_FULL, 1'b1);
				end else begin
					slot = (pos > entries.size()) ? entries.size() : pos;
					entries.insert(slot, val);
					if (entries.size() > peak)
						peak = entries.size();
					push_word('0, STAT_OK, 1'b1);
				end
			end
			CMD_DELETE: begin
				if (pos >= entries.size()) begin
					missing_pos++;
					push_word('0, STAT_NOPOS, 1'b1);
				end else begin
					entries.delete(pos);
					push_word('0, STAT_OK, 1'b1);
				end
			end
			CMD_DUMP: begin
				dumps++;
				if (entries.size() == 0)
					push_word('0, STAT_EMPTY, 1'b1);
				else
					foreach (entries[i])
						push_word(entries[i], STAT_OK, i == entries.size() - 1);
			end
			default: begin
				push_word('0, STAT_OK, 1'b1);
			end
			endcase
		endfunction

		// compare one output word with the oldest one owed
		function void check_word(logic signed [DATA_W-1:0] value, logic [ECNT_W-1:0] count,
				logic [1:0] stat, logic last);
			list_word_t w;
			words_seen++;
			if (owed.size() == 0) begin
				failures++;
				$display("%0t: unexpected word value=%0d count=%0d status=%0d last=%0d",
					$time, value, count, stat, last);
				return;
			end
			w = owed.pop_front();
			if (value !== w.value) begin
				failures++;
				$display("%0t: value_out expected %0d got %0d", $time, w.value, value);
			end
			if (count !== w.count) begin
				failures++;
				$display("%0t: entry_count expected %0d got %0d", $time, w.count, count);
			end
			if (stat !== w.stat) begin
				failures++;
				$display("%0t: status expected %0d got %0d", $time, w.stat, stat);
			end
			if (last !== w.last) begin
				failures++;
				$display("%0t: last expected %0d got %0d", $time, w.last, last);
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               command;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value_in;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] value_out;
	logic [ECNT_W-1:0]        entry_count;
	logic [1:0]               status;
	logic                     last;

	list_tracker tracker;
	bit          idling_on;
	int unsigned quiet_cycles;

	positional_list_insert_delete_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.position    (position),
		.value_in    (value_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value_out   (value_out),
		.entry_count (entry_count),
		.status      (status),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// stall the result side now and then
	always @(negedge clk) begin
		out_stall <= idling_on && ($urandom_range(99) < 8);
	end

	// check results first, then note the command taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_word(value_out, entry_count, status, last);
			if (in_valid && !in_stall)
				tracker.note_command(command, position, value_in);
		end
	end

	// give up when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("positional_list_insert_delete_core test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one command word and hold it until taken
	task automatic send_command(input logic [1:0] cmd, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		@(negedge clk);
		while (idling_on && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		position <= pos;
		value_in <= val;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
	endtask

	// hold off the sender until every owed word has come out
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.owed.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int unsigned held;
		int unsigned roll;
		logic [1:0] cmd;
		logic [POS_W-1:0] pos;
		logic signed [DATA_W-1:0] val;
		int n;

		tracker   = new();
		idling_on = 1'b1;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		command   = CMD_INSERT;
		position  = '0;
		value_in  = '0;
		out_stall = 1'b0;
		quiet_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// empty list, spare code, extreme positions and values
		send_command(CMD_DUMP, 8'd0, 32'sd0);
		send_command(CMD_DELETE, 8'd0, 32'sd0);
		send_command(CMD_SPARE, 8'd0, 32'sd0);
		send_command(CMD_INSERT, 8'd255, 32'sh7FFFFFFF);
		send_command(CMD_INSERT, 8'd0, 32'sh80000000);
		send_command(CMD_INSERT, 8'd1, 32'sd0);
		send_command(CMD_INSERT, 8'd200, -32'sd1);
		send_command(CMD_DUMP, 8'd255, -32'sd1);
		send_command(CMD_DELETE, 8'd3, 32'sd0);
		send_command(CMD_DELETE, 8'd0, 32'sd0);
		send_command(CMD_DELETE, 8'd255, 32'sd0);
		send_command(CMD_DELETE, 8'd2, 32'sd0);
		send_command(CMD_INSERT, 8'd1, 32'sh55555555);
		send_command(CMD_INSERT, 8'd2, 32'shAAAAAAAA);
		send_command(CMD_DUMP, 8'd0, 32'sd0);
		send_command(CMD_SPARE, 8'd255, -32'sd1);
		wait_for_results();
		send_command(CMD_DELETE, 8'd1, 32'sd0);
		send_command(CMD_DELETE, 8'd0, 32'sd0);
		send_command(CMD_DELETE, 8'd0, 32'sd0);
		send_command(CMD_DELETE, 8'd0, 32'sd0);
		send_command(CMD_DUMP, 8'd0, 32'sd0);

		// fill until full inserts are refused, then start draining
		n = 0;
		while ((n < RANDOM_COMMANDS || tracker.full_rejects == 0) && n < RANDOM_CAP) begin
			idling_on = !(n >= 30 && n < 65);
			if (n == 50)
				wait_for_results();
			held = tracker.entries.size();
			roll = $urandom_range(99);
			if (tracker.full_rejects < 3)
				cmd = (roll < 86) ? CMD_INSERT : (roll < 92) ? CMD_DELETE :
					(roll < 98) ? CMD_DUMP : CMD_SPARE;
			else
				cmd = (roll < 25) ? CMD_INSERT : (roll < 85) ? CMD_DELETE :
					(roll < 97) ? CMD_DUMP : CMD_SPARE;
			pos = ($urandom_range(99) < 80) ? POS_W'($urandom_range(held)) :
				POS_W'($urandom_range(255));
			roll = $urandom_range(99);
			if (roll < 5)
				val = 32'sh7FFFFFFF;
			else if (roll < 10)
				val = 32'sh80000000;
			else
				val = $urandom;
			send_command(cmd, pos, val);
			n++;
		end
		idling_on = 1'b1;

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d commands giving %0d words, %0d of them dumps; list peaked at %0d.",
			tracker.commands_seen, tracker.words_seen, tracker.dumps, tracker.peak);
		$display("Refused %0d inserts on a full list and %0d deletes past the end.",
			tracker.full_rejects, tracker.missing_pos);
		if (tracker.failures == 0 && tracker.owed.size() == 0)
			$display("positional_list_insert_delete_core test passed");
		else
			$display("positional_list_insert_delete_core test failed");
		$finish;
	end

endmodule
